>>> hw/rtl/rdct_pkg.sv
// Shared types, register map constants and bit layout for the timer bank.
`timescale 1ns / 1ps
`default_nettype none

package rdct_pkg;

  localparam int CNT_W      = 16;
  localparam int NUM_TIMERS = 5;
  localparam int NUM_CMP    = 4;
  localparam int CTRL_W     = 23;
  localparam int DATA_W     = 32;
  localparam int OFF_W      = 8;
  localparam int BIT_IDX_W  = $clog2(CTRL_W);

  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [OFF_W-1:0]    reg_offset;
    logic [DATA_W-1:0]   write_value;
  } rdct_in_t;

  typedef struct packed {
    logic [DATA_W-1:0]     read_value;
    logic [NUM_TIMERS-1:0] expired_mask;
  } rdct_out_t;

  // Handshake status from the input stage to the output stage
  typedef struct packed {
    logic item_valid;
    logic fire;
  } rdct_stage_t;

  localparam logic [OFF_W-1:0] REG_PRESCALE = 8'h00;
  localparam logic [OFF_W-1:0] REG_MUX      = 8'h04;
  localparam logic [OFF_W-1:0] REG_CONTROL  = 8'h08;
  localparam logic [OFF_W-1:0] REG_LIVE4    = 8'h40;

  function automatic logic [OFF_W-1:0] cnt_buf_off(input int n);
    return OFF_W'(12 + 12 * n);
  endfunction

  function automatic logic [OFF_W-1:0] cmp_buf_off(input int n);
    return OFF_W'(16 + 12 * n);
  endfunction

  function automatic logic [OFF_W-1:0] live_off(input int n);
    if (n < NUM_CMP) return OFF_W'(20 + 12 * n);
    return REG_LIVE4;
  endfunction

  function automatic logic [BIT_IDX_W-1:0] start_bit(input int n);
    if (n == 0) return BIT_IDX_W'(0);
    return BIT_IDX_W'(4 * (n - 1) + 8);
  endfunction

  function automatic logic [BIT_IDX_W-1:0] manual_bit(input int n);
    if (n == 0) return BIT_IDX_W'(1);
    return BIT_IDX_W'(4 * (n - 1) + 9);
  endfunction

  function automatic logic [BIT_IDX_W-1:0] reload_bit(input int n);
    if (n == 0) return BIT_IDX_W'(3);
    if (n == 4) return BIT_IDX_W'(22);
    return BIT_IDX_W'(4 * (n - 1) + 11);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rdct_in_reg.sv
// Input register: captures one item and holds it until the bank takes it.
`timescale 1ns / 1ps
`default_nettype none

module rdct_in_reg
  import rdct_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rdct_in_t in_data,
  input  wire logic     advance,
  output rdct_stage_t   stage,
  output rdct_in_t      item
);

  logic     valid_r, valid_nxt;
  rdct_in_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign stage.item_valid = valid_r;
  assign stage.fire       = valid_r && advance;
  assign item             = item_r;

endmodule

`default_nettype wire

>>> hw/rtl/rdct_bank.sv
// Timer state, register map decode and per-item update.
`timescale 1ns / 1ps
`default_nettype none

module rdct_bank
  import rdct_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     fire,
  input  wire rdct_in_t item,
  output rdct_out_t     result
);

  logic [DATA_W-1:0] prescale_r, prescale_nxt;
  logic [DATA_W-1:0] mux_r, mux_nxt;
  logic [CTRL_W-1:0] ctrl_r, ctrl_nxt;
  logic [CNT_W-1:0]  cnt_buf_r [NUM_TIMERS];
  logic [CNT_W-1:0]  cnt_buf_nxt [NUM_TIMERS];
  logic [CNT_W-1:0]  cmp_buf_r [NUM_CMP];
  logic [CNT_W-1:0]  cmp_buf_nxt [NUM_CMP];
  logic [CNT_W-1:0]  live_r [NUM_TIMERS];
  logic [CNT_W-1:0]  live_nxt [NUM_TIMERS];

  always_comb begin
    prescale_nxt = prescale_r;
    mux_nxt      = mux_r;
    ctrl_nxt     = ctrl_r;
    cnt_buf_nxt  = cnt_buf_r;
    cmp_buf_nxt  = cmp_buf_r;
    live_nxt     = live_r;
    result       = '0;
    case (item.action)
      ACT_TICK: begin
        for (int n = 0; n < NUM_TIMERS; n++) begin
          if (ctrl_r[manual_bit(n)]) begin
            live_nxt[n] = cnt_buf_r[n];
          end else if (ctrl_r[start_bit(n)]) begin
            if (live_r[n] == '0) begin
              result.expired_mask[n] = 1'b1;
              // expire: reload or stop
              if (ctrl_r[reload_bit(n)]) begin
                live_nxt[n] = cnt_buf_r[n];
              end else begin
                ctrl_nxt[start_bit(n)] = 1'b0;
              end
            end else begin
              live_nxt[n] = live_r[n] - CNT_W'(1);
            end
          end
        end
      end
      ACT_WRITE: begin
        if (item.reg_offset == REG_PRESCALE) prescale_nxt = item.write_value;
        if (item.reg_offset == REG_MUX)      mux_nxt      = item.write_value;
        if (item.reg_offset == REG_CONTROL)  ctrl_nxt     = item.write_value[CTRL_W-1:0];
        for (int n = 0; n < NUM_TIMERS; n++) begin
          if (item.reg_offset == cnt_buf_off(n)) begin
            cnt_buf_nxt[n] = item.write_value[CNT_W-1:0];
          end
        end
        for (int n = 0; n < NUM_CMP; n++) begin
          if (item.reg_offset == cmp_buf_off(n)) begin
            cmp_buf_nxt[n] = item.write_value[CNT_W-1:0];
          end
        end
        // manual update sees the values just written
        for (int n = 0; n < NUM_TIMERS; n++) begin
          if (ctrl_nxt[manual_bit(n)]) live_nxt[n] = cnt_buf_nxt[n];
        end
      end
      ACT_READ: begin
        if (item.reg_offset == REG_PRESCALE) result.read_value = prescale_r;
        if (item.reg_offset == REG_MUX)      result.read_value = mux_r;
        if (item.reg_offset == REG_CONTROL)  result.read_value = DATA_W'(ctrl_r);
        for (int n = 0; n < NUM_TIMERS; n++) begin
          if (item.reg_offset == cnt_buf_off(n)) result.read_value = DATA_W'(cnt_buf_r[n]);
          if (item.reg_offset == live_off(n))    result.read_value = DATA_W'(live_r[n]);
        end
        for (int n = 0; n < NUM_CMP; n++) begin
          if (item.reg_offset == cmp_buf_off(n)) result.read_value = DATA_W'(cmp_buf_r[n]);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prescale_r <= '0;
      mux_r      <= '0;
      ctrl_r     <= '0;
      for (int n = 0; n < NUM_TIMERS; n++) begin
        cnt_buf_r[n] <= '0;
        live_r[n]    <= '0;
      end
      for (int n = 0; n < NUM_CMP; n++) begin
        cmp_buf_r[n] <= '0;
      end
    end else if (fire) begin
      prescale_r <= prescale_nxt;
      mux_r      <= mux_nxt;
      ctrl_r     <= ctrl_nxt;
      cnt_buf_r  <= cnt_buf_nxt;
      cmp_buf_r  <= cmp_buf_nxt;
      live_r     <= live_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rdct_out_reg.sv
// Result register: holds one result until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none

module rdct_out_reg
  import rdct_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire rdct_stage_t stage,
  input  wire rdct_out_t   result,
  output logic             advance,
  output logic             out_valid,
  input  wire logic        out_ready,
  output rdct_out_t        out_data
);

  logic      valid_r, valid_nxt;
  rdct_out_t data_r;

  assign advance   = !valid_r || out_ready;
  assign valid_nxt = advance ? stage.item_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stage.fire) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

>>> hw/rtl/reload_down_counter_timer_bank_top.sv
// Top level of the five-timer auto-reload down-counter bank.
`timescale 1ns / 1ps
`default_nettype none

// Five 16-bit down-counting timers behind a word register map. Each transfer on the
// input channel is a register read, a register write, one tick or a no-op, and
// gives exactly one result: the read data (zero otherwise) and a mask of timers
// that were at zero on a tick. An item passes an input register and one pass of
// decode/update logic into the result register, and one
// item is taken every cycle while the result side keeps up; a stalled result
// register holds one item in the input register, then in_ready drops.

module reload_down_counter_timer_bank_top
  import rdct_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire rdct_in_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output rdct_out_t     out_data
);

  logic        advance;
  rdct_stage_t stage;
  rdct_in_t    item;
  rdct_out_t   result;

  rdct_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .stage    (stage),
    .item     (item)
  );

  rdct_bank u_bank (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (stage.fire),
    .item   (item),
    .result (result)
  );

  rdct_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.item_valid && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while both stages are full");

  a_transfer_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> stage.item_valid)
    else $error("accepted item lost from input register");

  a_mask_only_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.fire && item.action != ACT_TICK) |=> (out_data.expired_mask == '0))
    else $error("expiry reported on a non-tick item");

  a_data_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (stage.fire && item.action != ACT_READ) |=> (out_data.read_value == '0))
    else $error("read data on a non-read item");
`endif

endmodule

`default_nettype wire
